>>> hw/rtl/lrhf_pkg.sv
// Package for the LUT remap block with hole fill.
// Holds sizes, item kind codes, register indexes, state types and the frame request bundle.
// No dependencies.
package lrhf_pkg;

	localparam int MAP_WIDTH   = 640;
	localparam int MAP_HEIGHT  = 480;
	localparam int MAP_DEPTH   = 2 * MAP_WIDTH * MAP_HEIGHT;
	localparam int MAP_AW      = $clog2(MAP_DEPTH);
	localparam int MAP_SIDE_SZ = MAP_WIDTH * MAP_HEIGHT;

	localparam int FRAME_COLS  = 640;
	localparam int FRAME_ROWS  = 480;
	localparam int FRAME_DEPTH = FRAME_COLS * FRAME_ROWS;
	localparam int FRAME_AW    = $clog2(FRAME_DEPTH);

	localparam logic [7:0] HOLE       = 8'd254;
	localparam logic [7:0] HOLE_SUBST = 8'd253;
	localparam logic [7:0] BLOCKER    = 8'd255;

	localparam logic [2:0] KIND_MAP   = 3'd0;
	localparam logic [2:0] KIND_CLEAR = 3'd1;
	localparam logic [2:0] KIND_PIXEL = 3'd2;
	localparam logic [2:0] KIND_FILL  = 3'd3;
	localparam logic [2:0] KIND_READ  = 3'd4;

	localparam logic [2:0] CFG_TABLE_SELECT = 3'd0;
	localparam logic [2:0] CFG_SCALE_SHIFT  = 3'd1;
	localparam logic [2:0] CFG_FRAME_COLS   = 3'd2;
	localparam logic [2:0] CFG_FRAME_ROWS   = 3'd3;
	localparam logic [2:0] CFG_FILL_ENABLE  = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PIX,
		ST_RD_ADDR,
		ST_RD_DATA,
		ST_CLEAR,
		ST_FILL
	} top_state_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_SCAN,
		F_DIV,
		F_WRITE
	} fill_state_t;

	typedef struct packed {
		logic                we;
		logic [FRAME_AW-1:0] waddr;
		logic [7:0]          wdata;
		logic [FRAME_AW-1:0] raddr;
	} frame_req_t;

	// Frame address offset of the 3x3 window entry; entry 0 is the center.
	function automatic logic [FRAME_AW-1:0] nb_offset(input logic [3:0] idx);
		logic [FRAME_AW-1:0] off;
		case (idx)
			4'd1:    off = FRAME_AW'(-FRAME_COLS - 1);
			4'd2:    off = FRAME_AW'(-FRAME_COLS);
			4'd3:    off = FRAME_AW'(-FRAME_COLS + 1);
			4'd4:    off = FRAME_AW'(-1);
			4'd5:    off = FRAME_AW'(1);
			4'd6:    off = FRAME_AW'(FRAME_COLS - 1);
			4'd7:    off = FRAME_AW'(FRAME_COLS);
			4'd8:    off = FRAME_AW'(FRAME_COLS + 1);
			default: off = '0;
		endcase
		return off;
	endfunction

endpackage

>>> hw/rtl/lrhf_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module lrhf_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> hw/rtl/lrhf_fill.sv
// Hole fill sequencer: column-major in-place walk over the frame interior.
// Depends on lrhf_pkg; drives the frame RAM through frame_req_t.
module lrhf_fill (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [9:0]          cols,
	input  logic [8:0]          rows,
	input  logic [7:0]          rdata,
	output lrhf_pkg::frame_req_t req,
	output logic                done
);
	import lrhf_pkg::*;

	fill_state_t         st_q, st_d;
	logic [9:0]          i_q, i_d;
	logic [8:0]          j_q, j_d;
	logic [3:0]          idx_q, idx_d;
	logic                v_s1, v_s1_d;
	logic [3:0]          idx_s1, idx_s1_d;
	logic [10:0]         sum_q, sum_d, nsum;
	logic [3:0]          cnt_q, cnt_d, ncnt;
	logic                blk_q, blk_d, nblk;
	logic [10:0]         dsum_q, dsum_d;
	logic [3:0]          rem_q, rem_d;
	logic [10:0]         quo_q, quo_d;
	logic [3:0]          divc_q, divc_d;
	logic [4:0]          remsh;
	logic [FRAME_AW-1:0] ctr;
	logic                last_j, last_i, adv;

	assign ctr    = FRAME_AW'(j_q) * FRAME_AW'(FRAME_COLS) + FRAME_AW'(i_q);
	assign last_j = ({1'b0, j_q} + 10'd2) == {1'b0, rows};
	assign last_i = (i_q + 10'd2) == cols;
	assign remsh  = {rem_q, dsum_q[10]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= F_IDLE;
			v_s1  <= 1'b0;
		end else begin
			st_q  <= st_d;
			v_s1  <= v_s1_d;
		end
	end

	always_ff @(posedge clk) begin
		i_q    <= i_d;
		j_q    <= j_d;
		idx_q  <= idx_d;
		idx_s1 <= idx_s1_d;
		sum_q  <= sum_d;
		cnt_q  <= cnt_d;
		blk_q  <= blk_d;
		dsum_q <= dsum_d;
		rem_q  <= rem_d;
		quo_q  <= quo_d;
		divc_q <= divc_d;
	end

	always_comb begin
		st_d     = st_q;
		i_d      = i_q;
		j_d      = j_q;
		idx_d    = idx_q;
		v_s1_d   = 1'b0;
		idx_s1_d = idx_q;
		sum_d    = sum_q;
		cnt_d    = cnt_q;
		blk_d    = blk_q;
		dsum_d   = dsum_q;
		rem_d    = rem_q;
		quo_d    = quo_q;
		divc_d   = divc_q;
		done     = 1'b0;
		adv      = 1'b0;
		req.we    = 1'b0;
		req.waddr = ctr;
		req.wdata = quo_q[7:0];
		req.raddr = ctr + nb_offset(idx_q);

		nblk = blk_q;
		nsum = sum_q;
		ncnt = cnt_q;
		if (rdata == BLOCKER) begin
			nblk = 1'b1;
		end else if (rdata < HOLE) begin
			nsum = sum_q + 11'(rdata);
			ncnt = cnt_q + 4'd1;
		end

		case (st_q)
			F_IDLE: begin
				if (start) begin
					st_d  = F_SCAN;
					i_d   = 10'd1;
					j_d   = 9'd1;
					idx_d = '0;
					sum_d = '0;
					cnt_d = '0;
					blk_d = 1'b0;
				end
			end
			F_SCAN: begin
				// one read issued per cycle, data checked in the next cycle
				if (idx_q <= 4'd8) begin
					idx_d  = idx_q + 4'd1;
					v_s1_d = 1'b1;
				end
				if (v_s1) begin
					if (idx_s1 == 4'd0) begin
						if (rdata != HOLE) begin
							adv = 1'b1;
						end
					end else begin
						blk_d = nblk;
						sum_d = nsum;
						cnt_d = ncnt;
						if (idx_s1 == 4'd8) begin
							if (nblk || ncnt == 4'd0) begin
								adv = 1'b1;
							end else begin
								st_d   = F_DIV;
								dsum_d = nsum;
								rem_d  = '0;
								quo_d  = '0;
								divc_d = 4'd11;
							end
						end
					end
				end
			end
			F_DIV: begin
				// restoring division, one quotient bit per cycle
				dsum_d = {dsum_q[9:0], 1'b0};
				divc_d = divc_q - 4'd1;
				if (remsh >= {1'b0, cnt_q}) begin
					rem_d = 4'(remsh - {1'b0, cnt_q});
					quo_d = {quo_q[9:0], 1'b1};
				end else begin
					rem_d = remsh[3:0];
					quo_d = {quo_q[9:0], 1'b0};
				end
				if (divc_q == 4'd1) begin
					st_d = F_WRITE;
				end
			end
			F_WRITE: begin
				req.we = 1'b1;
				st_d   = F_SCAN;
				adv    = 1'b1;
			end
			default: st_d = F_IDLE;
		endcase

		if (adv) begin
			idx_d  = '0;
			v_s1_d = 1'b0;
			sum_d  = '0;
			cnt_d  = '0;
			blk_d  = 1'b0;
			st_d   = F_SCAN;
			if (last_j) begin
				j_d = 9'd1;
				if (last_i) begin
					st_d = F_IDLE;
					done = 1'b1;
				end else begin
					i_d = i_q + 10'd1;
				end
			end else begin
				j_d = j_q + 9'd1;
			end
		end
	end
endmodule

>>> hw/rtl/lut_remap_with_hole_fill.sv
// Top level of the LUT remap block with hole fill.
// Depends on lrhf_pkg, lrhf_ram (map table and frame) and lrhf_fill.
//
// Forward-scatter rectification. A map entry item (kind 0) writes one target
// into the two-sided map table. A pixel item (kind 2) reads the map at its
// position scaled up by 2^scale_shift and writes its gray (254 becomes 253)
// at the target scaled down, a map RAM read then a frame RAM write. A read
// item (kind 4) goes through the frame RAM read port and then waits in the
// output register; it is the only item that gives a result. A clear item
// (kind 1) sweeps all 307200 frame entries with the hole marker, one per
// cycle. A fill item (kind 3, only when fill_enable is set) walks the
// interior in column-major order: per position it reads the center and,
// when that is a hole, its eight neighbours, then runs the mean divider and
// write-back when it gets a value. Reading the frame before the first clear
// is undefined. Frame sizes are used saturated to 3..640 columns and
// 3..480 rows.
module lut_remap_with_hole_fill (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [9:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] kind,
	input  logic       table_side,
	input  logic [9:0] map_col,
	input  logic [8:0] map_row,
	input  logic [9:0] target_col,
	input  logic [8:0] target_row,
	input  logic [9:0] pixel_col,
	input  logic [8:0] pixel_row,
	input  logic [7:0] gray,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_gray,
	output logic       is_hole
);
	import lrhf_pkg::*;

	// configuration registers
	logic       table_select_q;
	logic [1:0] scale_shift_q;
	logic [9:0] frame_cols_q;
	logic [8:0] frame_rows_q;
	logic       fill_enable_q;
	logic [9:0] cols;
	logic [8:0] rows;

	top_state_t          st_q, st_d;
	logic                accept, out_free;
	logic                pix_ok_q;
	logic [7:0]          gray_q;
	logic [FRAME_AW-1:0] rd_addr_q;
	logic                rd_off_q;
	logic [FRAME_AW-1:0] clr_q;
	logic                out_valid_q;
	logic [7:0]          read_gray_q;
	logic                is_hole_q;

	// map RAM
	logic                map_we;
	logic [MAP_AW-1:0]   map_waddr, map_raddr;
	logic [18:0]         map_rdata;
	logic [12:0]         sc, sr;
	logic                pix_in_frame, pix_in_map;
	logic [9:0]          xc;
	logic [8:0]          xr;

	// frame RAM
	frame_req_t          freq, fill_req;
	logic [7:0]          frame_rdata;
	logic                fill_start, fill_done;
	logic                rd_in_frame;

	assign cols = (frame_cols_q < 10'd3) ? 10'd3 :
	              (frame_cols_q > 10'(FRAME_COLS)) ? 10'(FRAME_COLS) : frame_cols_q;
	assign rows = (frame_rows_q < 9'd3) ? 9'd3 :
	              (frame_rows_q > 9'(FRAME_ROWS)) ? 9'(FRAME_ROWS) : frame_rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_select_q <= 1'b0;
			scale_shift_q  <= 2'd0;
			frame_cols_q   <= 10'd640;
			frame_rows_q   <= 9'd480;
			fill_enable_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TABLE_SELECT: table_select_q <= cfg_data[0];
				CFG_SCALE_SHIFT:  scale_shift_q  <= cfg_data[1:0];
				CFG_FRAME_COLS:   frame_cols_q   <= cfg_data;
				CFG_FRAME_ROWS:   frame_rows_q   <= cfg_data[8:0];
				CFG_FILL_ENABLE:  fill_enable_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign in_stall = (st_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// map entry write and pixel lookup address
	assign map_we    = accept && kind == KIND_MAP && 32'(map_col) < MAP_WIDTH
	                   && 32'(map_row) < MAP_HEIGHT;
	assign map_waddr = MAP_AW'(table_side) * MAP_AW'(MAP_SIDE_SZ)
	                 + MAP_AW'(map_row) * MAP_AW'(MAP_WIDTH) + MAP_AW'(map_col);
	assign sc        = 13'(pixel_col) << scale_shift_q;
	assign sr        = 13'(pixel_row) << scale_shift_q;
	assign pix_in_frame = pixel_col < cols && pixel_row < rows;
	assign pix_in_map   = 32'(sc) < MAP_WIDTH && 32'(sr) < MAP_HEIGHT;
	assign map_raddr = MAP_AW'(table_select_q) * MAP_AW'(MAP_SIDE_SZ)
	                 + MAP_AW'(sr) * MAP_AW'(MAP_WIDTH) + MAP_AW'(sc);
	assign rd_in_frame = pix_in_frame;

	// scaled-down target from the map entry read back
	assign xc = map_rdata[9:0] >> scale_shift_q;
	assign xr = map_rdata[18:10] >> scale_shift_q;

	lrhf_ram #(.DEPTH(MAP_DEPTH), .WIDTH(19)) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata ({target_row, target_col}),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	lrhf_ram #(.DEPTH(FRAME_DEPTH), .WIDTH(8)) u_frame (
		.clk   (clk),
		.we    (freq.we),
		.waddr (freq.waddr),
		.wdata (freq.wdata),
		.raddr (freq.raddr),
		.rdata (frame_rdata)
	);

	lrhf_fill u_fill (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (fill_start),
		.cols   (cols),
		.rows   (rows),
		.rdata  (frame_rdata),
		.req    (fill_req),
		.done   (fill_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_RD_DATA && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_ok_q  <= pix_in_frame && pix_in_map;
			gray_q    <= (gray == HOLE) ? HOLE_SUBST : gray;
			rd_addr_q <= FRAME_AW'(pixel_row) * FRAME_AW'(FRAME_COLS) + FRAME_AW'(pixel_col);
			rd_off_q  <= !rd_in_frame;
			clr_q     <= '0;
		end else if (st_q == ST_CLEAR) begin
			clr_q <= clr_q + FRAME_AW'(1);
		end
		if (st_q == ST_RD_DATA && out_free) begin
			read_gray_q <= rd_off_q ? 8'd0 : frame_rdata;
			is_hole_q   <= !rd_off_q && frame_rdata == HOLE;
		end
	end

	always_comb begin
		st_d       = st_q;
		fill_start = 1'b0;
		freq.we    = 1'b0;
		freq.waddr = FRAME_AW'(xr) * FRAME_AW'(FRAME_COLS) + FRAME_AW'(xc);
		freq.wdata = gray_q;
		freq.raddr = rd_addr_q;
		case (st_q)
			ST_IDLE: begin
				if (accept) begin
					case (kind)
						KIND_CLEAR: st_d = ST_CLEAR;
						KIND_PIXEL: st_d = ST_PIX;
						KIND_READ:  st_d = ST_RD_ADDR;
						KIND_FILL: begin
							if (fill_enable_q) begin
								st_d       = ST_FILL;
								fill_start = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			ST_PIX: begin
				freq.we = pix_ok_q && xc < cols && xr < rows;
				st_d    = ST_IDLE;
			end
			ST_RD_ADDR: st_d = ST_RD_DATA;
			ST_RD_DATA: begin
				// address held, so the read data stays valid while the output waits
				if (out_free) begin
					st_d = ST_IDLE;
				end
			end
			ST_CLEAR: begin
				freq.we    = 1'b1;
				freq.waddr = clr_q;
				freq.wdata = HOLE;
				if (clr_q == FRAME_AW'(FRAME_DEPTH - 1)) begin
					st_d = ST_IDLE;
				end
			end
			ST_FILL: begin
				freq = fill_req;
				if (fill_done) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;
	assign read_gray = read_gray_q;
	assign is_hole   = is_hole_q;
endmodule
